>>> src/cbm_pkg.sv
// cbm_pkg: shared types, codes and constants of the cartridge bank mapper.
// No dependencies; imported by every module of the block.
package cbm_pkg;

    localparam int unsigned MEM_ADDR_W  = 23;
    localparam int unsigned SRAM_ADDR_W = 17;

    // Mask width ceilings.
    localparam logic [4:0] ROM_ADDR_BITS  = 5'd23;
    localparam logic [4:0] SRAM_ADDR_BITS = 5'd17;

    // Bus operations.
    localparam logic [1:0] OP_ROM_READ     = 2'd0;
    localparam logic [1:0] OP_MAPPER_WRITE = 2'd1;
    localparam logic [1:0] OP_SRAM_READ    = 2'd2;
    localparam logic [1:0] OP_SRAM_WRITE   = 2'd3;

    // Memory select codes.
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_ROM  = 2'd1;
    localparam logic [1:0] SEL_SRAM = 2'd2;

    // Mapper types.
    localparam logic [2:0] MAPPER_NONE  = 3'd0;
    localparam logic [2:0] MAPPER_TYPE1 = 3'd1;
    localparam logic [2:0] MAPPER_TYPE2 = 3'd2;
    localparam logic [2:0] MAPPER_TYPE3 = 3'd3;
    localparam logic [2:0] MAPPER_TYPE5 = 3'd4;

    // Config register indexes.
    localparam logic [2:0] CFG_MAPPER_TYPE      = 3'd0;
    localparam logic [2:0] CFG_MULTICART_WIRING = 3'd1;
    localparam logic [2:0] CFG_ROM_SIZE_BYTES   = 3'd2;
    localparam logic [2:0] CFG_ROM_SIZE_LOG2    = 3'd3;
    localparam logic [2:0] CFG_SRAM_SIZE_BYTES  = 3'd4;
    localparam logic [2:0] CFG_SRAM_SIZE_LOG2   = 3'd5;

    // Register write decode constants.
    localparam logic [23:0] BIG_ROM_LIMIT  = 24'h080000;
    localparam logic [3:0]  RAM_ENABLE_KEY = 4'ha;
    localparam logic [7:0]  KEEP_MULTICART = 8'hcf;
    localparam logic [7:0]  KEEP_STANDARD  = 8'h9f;

    typedef struct packed {
        logic [1:0]  op;
        logic [14:0] bus_address;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            mem_select;
        logic [MEM_ADDR_W-1:0] mem_address;
        logic                  mem_hit;
        logic                  mem_write;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  mapper_type;
        logic        multicart_wiring;
        logic [23:0] rom_size_bytes;
        logic [4:0]  rom_size_log2;
        logic [17:0] sram_size_bytes;
        logic [4:0]  sram_size_log2;
    } cfg_t;

    typedef struct packed {
        logic [8:0] fixed_rom_bank;
        logic [8:0] switch_rom_bank;
        logic [8:0] ram_low_half_bank;
        logic [8:0] ram_high_half_bank;
        logic       ram_enable;
        logic       mode_bit;
        logic [7:0] low_bank_reg;
        logic [1:0] upper_bank_reg;
    } bank_state_t;

endpackage

>>> src/cbm_bank_regs.sv
// cbm_bank_regs: bank, RAM enable and mode registers with the mapper write decode.
// Depends on cbm_pkg.
module cbm_bank_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [14:0]         wr_address,
    input  logic [7:0]          wr_data,
    input  cbm_pkg::cfg_t       cfg,
    output cbm_pkg::bank_state_t bank
);
    import cbm_pkg::*;

    bank_state_t bank_reg;
    bank_state_t bank_next;

    logic       big_rom;
    logic       ram_key;
    logic [4:0] low_sel;
    logic [7:0] up_new_sh;
    logic [7:0] up_old_sh;
    logic [7:0] keep_mask;
    logic [7:0] low_t1;

    always_comb
    begin
        big_rom   = cfg.rom_size_bytes > BIG_ROM_LIMIT;
        ram_key   = wr_data[3:0] == RAM_ENABLE_KEY;
        low_sel   = (wr_data[4:0] == 5'd0) ? 5'd1 : wr_data[4:0];
        up_new_sh = cfg.multicart_wiring ? {2'b00, wr_data[1:0], 4'b0000}
                                         : {1'b0, wr_data[1:0], 5'b00000};
        up_old_sh = cfg.multicart_wiring ? {2'b00, bank_reg.upper_bank_reg, 4'b0000}
                                         : {1'b0, bank_reg.upper_bank_reg, 5'b00000};
        keep_mask = cfg.multicart_wiring ? KEEP_MULTICART : KEEP_STANDARD;
        low_t1    = cfg.multicart_wiring ? {bank_reg.low_bank_reg[7:4], low_sel[3:0]}
                                         : {bank_reg.low_bank_reg[7:5], low_sel};
        bank_next = bank_reg;

        if (wr_en)
        begin
            unique case (cfg.mapper_type)
                MAPPER_TYPE1:
                begin
                    unique case (wr_address[14:13])
                        2'd0: bank_next.ram_enable = ram_key;
                        2'd1:
                        begin
                            bank_next.low_bank_reg    = low_t1;
                            bank_next.switch_rom_bank = {1'b0, low_t1};
                        end
                        2'd2:
                        begin
                            bank_next.upper_bank_reg = wr_data[1:0];
                            if (big_rom)
                            begin
                                if (bank_reg.mode_bit)
                                    bank_next.fixed_rom_bank = {1'b0, up_new_sh};
                                bank_next.low_bank_reg =
                                    (bank_reg.low_bank_reg & keep_mask) | up_new_sh;
                                bank_next.switch_rom_bank =
                                    {1'b0, (bank_reg.low_bank_reg & keep_mask) | up_new_sh};
                            end
                            else if (bank_reg.mode_bit)
                            begin
                                bank_next.ram_low_half_bank  = {6'd0, wr_data[1:0], 1'b0};
                                bank_next.ram_high_half_bank = {6'd0, wr_data[1:0], 1'b1};
                            end
                        end
                        default:
                        begin
                            bank_next.mode_bit = wr_data[0];
                            if (wr_data[0])
                            begin
                                if (big_rom)
                                    bank_next.fixed_rom_bank = {1'b0, up_old_sh};
                                else
                                begin
                                    bank_next.ram_low_half_bank =
                                        {6'd0, bank_reg.upper_bank_reg, 1'b0};
                                    bank_next.ram_high_half_bank =
                                        {6'd0, bank_reg.upper_bank_reg, 1'b1};
                                end
                            end
                            else
                            begin
                                bank_next.fixed_rom_bank     = 9'd0;
                                bank_next.ram_low_half_bank  = 9'd0;
                                bank_next.ram_high_half_bank = 9'd1;
                            end
                        end
                    endcase
                end
                MAPPER_TYPE2:
                begin
                    if (!wr_address[14])
                    begin
                        if (wr_address[8])
                            bank_next.switch_rom_bank = (wr_data[3:0] == 4'd0)
                                ? 9'd1 : {5'd0, wr_data[3:0]};
                        else
                            bank_next.ram_enable = ram_key;
                    end
                end
                MAPPER_TYPE3:
                begin
                    unique case (wr_address[14:13])
                        2'd0: bank_next.ram_enable = ram_key;
                        2'd1:
                            bank_next.switch_rom_bank = (wr_data[6:0] == 7'd0)
                                ? 9'd1 : {2'd0, wr_data[6:0]};
                        2'd2:
                        begin
                            bank_next.ram_low_half_bank  = {4'd0, wr_data[3:0], 1'b0};
                            bank_next.ram_high_half_bank = {4'd0, wr_data[3:0], 1'b1};
                        end
                        default:
                        begin
                            // Latch sequence 0 then 1 toggles the clock latch flag.
                            if (bank_reg.low_bank_reg == 8'd0 && wr_data == 8'd1)
                                bank_next.mode_bit = ~bank_reg.mode_bit;
                            bank_next.low_bank_reg = wr_data;
                        end
                    endcase
                end
                MAPPER_TYPE5:
                begin
                    unique case (wr_address[14:13])
                        2'd0: bank_next.ram_enable = ram_key;
                        2'd1:
                        begin
                            if (!wr_address[12])
                            begin
                                bank_next.low_bank_reg    = wr_data;
                                bank_next.switch_rom_bank = {bank_reg.mode_bit, wr_data};
                            end
                            else
                            begin
                                bank_next.mode_bit        = wr_data[0];
                                bank_next.switch_rom_bank =
                                    {wr_data[0], bank_reg.low_bank_reg};
                            end
                        end
                        2'd2:
                        begin
                            bank_next.ram_low_half_bank  = {wr_data, 1'b0};
                            bank_next.ram_high_half_bank = {wr_data, 1'b1};
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg.fixed_rom_bank     <= 9'd0;
            bank_reg.switch_rom_bank    <= 9'd1;
            bank_reg.ram_low_half_bank  <= 9'd0;
            bank_reg.ram_high_half_bank <= 9'd1;
            bank_reg.ram_enable         <= 1'b0;
            bank_reg.mode_bit           <= 1'b0;
            bank_reg.low_bank_reg       <= 8'd0;
            bank_reg.upper_bank_reg     <= 2'd0;
        end
        else
        begin
            bank_reg <= bank_next;
        end
    end

    assign bank = bank_reg;

endmodule

>>> src/cbm_addr_map.sv
// cbm_addr_map: forms the banked, size-masked ROM or SRAM address and hit flag.
// Depends on cbm_pkg.
module cbm_addr_map (
    input  cbm_pkg::in_item_t    item,
    input  cbm_pkg::bank_state_t bank,
    input  cbm_pkg::cfg_t        cfg,
    output cbm_pkg::out_item_t   result
);
    import cbm_pkg::*;

    logic [8:0]             rom_bank;
    logic [MEM_ADDR_W-1:0]  rom_raw;
    logic [4:0]             rom_lg;
    logic [MEM_ADDR_W-1:0]  rom_mask;
    logic [MEM_ADDR_W-1:0]  rom_addr;
    logic                   rom_hit;

    logic [8:0]             sram_bank;
    logic [20:0]            sram_raw;
    logic [4:0]             sram_lg;
    logic [SRAM_ADDR_W-1:0] sram_mask;
    logic [SRAM_ADDR_W-1:0] sram_addr;
    logic                   sram_hit;

    always_comb
    begin
        // ROM: low 16 KiB window uses the fixed bank, upper window the switchable one.
        rom_bank = item.bus_address[14] ? bank.switch_rom_bank : bank.fixed_rom_bank;
        rom_raw  = {rom_bank, item.bus_address[13:0]};
        rom_lg   = (cfg.rom_size_log2 > ROM_ADDR_BITS) ? ROM_ADDR_BITS : cfg.rom_size_log2;
        rom_mask = ~({MEM_ADDR_W{1'b1}} << rom_lg);
        rom_addr = rom_raw & rom_mask;
        rom_hit  = {1'b0, rom_addr} < cfg.rom_size_bytes;

        // SRAM: 8 KiB window split into two 4 KiB halves.
        sram_bank = item.bus_address[12] ? bank.ram_high_half_bank : bank.ram_low_half_bank;
        sram_raw  = {sram_bank, item.bus_address[11:0]};
        sram_lg   = (cfg.sram_size_log2 > SRAM_ADDR_BITS) ? SRAM_ADDR_BITS
                                                          : cfg.sram_size_log2;
        sram_mask = ~({SRAM_ADDR_W{1'b1}} << sram_lg);
        sram_addr = sram_raw[SRAM_ADDR_W-1:0] & sram_mask;
        sram_hit  = bank.ram_enable && ({1'b0, sram_addr} < cfg.sram_size_bytes);

        result = '0;
        unique case (item.op)
            OP_ROM_READ:
            begin
                result.mem_select  = SEL_ROM;
                result.mem_address = rom_addr;
                result.mem_hit     = rom_hit;
            end
            OP_MAPPER_WRITE: result = '0;
            default:
            begin
                result.mem_select  = SEL_SRAM;
                result.mem_address = {{(MEM_ADDR_W-SRAM_ADDR_W){1'b0}}, sram_addr};
                result.mem_hit     = sram_hit;
                result.mem_write   = (item.op == OP_SRAM_WRITE) && sram_hit;
            end
        endcase
    end

endmodule

>>> src/cartridge_bank_mapper_unit.sv
// cartridge_bank_mapper_unit: top level of the cartridge bank mapper.
// Depends on cbm_pkg, cbm_bank_regs and cbm_addr_map.
// Registers: stage 1 holds the accepted item, a single address-forming pass feeds
// the result register. Throughput: one item per cycle while out_stall is low.
// Reset: config regs to type none, 32 KiB ROM (mask 15), no SRAM; banks to
// fixed 0, switch 1, RAM halves 0/1, RAM disabled, mode 0; pipeline empty.
module cartridge_bank_mapper_unit (
    input  logic               clk,
    input  logic               rst_n,
    // input item channel
    input  logic               in_valid,
    output logic               in_stall,
    input  cbm_pkg::in_item_t  in_item,
    // result item channel
    output logic               out_valid,
    input  logic               out_stall,
    output cbm_pkg::out_item_t out_item,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import cbm_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers: user writes only while block is idle (unenforced).
    // ---------------------------------------------------------------
    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAPPER_TYPE:      cfg_next.mapper_type      = cfg_data[2:0];
                CFG_MULTICART_WIRING: cfg_next.multicart_wiring = cfg_data[0];
                CFG_ROM_SIZE_BYTES:   cfg_next.rom_size_bytes   = cfg_data;
                CFG_ROM_SIZE_LOG2:    cfg_next.rom_size_log2    = cfg_data[4:0];
                CFG_SRAM_SIZE_BYTES:  cfg_next.sram_size_bytes  = cfg_data[17:0];
                CFG_SRAM_SIZE_LOG2:   cfg_next.sram_size_log2   = cfg_data[4:0];
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mapper_type      <= MAPPER_NONE;
            cfg_reg.multicart_wiring <= 1'b0;
            cfg_reg.rom_size_bytes   <= 24'd32768;
            cfg_reg.rom_size_log2    <= 5'd15;
            cfg_reg.sram_size_bytes  <= 18'd0;
            cfg_reg.sram_size_log2   <= 5'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------
    // Handshake. Stage 1 holds the accepted item; stage 2 is the result
    // register. Stage 1 advances whenever the result register is empty or
    // being drained, so a waiting result does not block intake of one more
    // item.
    // ---------------------------------------------------------------
    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;

    logic      out_load;
    logic      s1_fire;
    logic      in_take;

    assign out_load = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Bank state: a mapper write updates it as the item leaves stage 1, so
    // the item right behind it already sees the new banks.
    // ---------------------------------------------------------------
    bank_state_t bank;
    out_item_t   result;

    cbm_bank_regs u_bank_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (s1_fire && (s1_item_reg.op == OP_MAPPER_WRITE)),
        .wr_address (s1_item_reg.bus_address),
        .wr_data    (s1_item_reg.write_data),
        .cfg        (cfg_reg),
        .bank       (bank)
    );

    cbm_addr_map u_addr_map (
        .item   (s1_item_reg),
        .bank   (bank),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Payload registers: no reset needed, qualified by the valid flags.
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_item;
        if (s1_fire)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_write_implies_sram_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.mem_write
            |-> out_item_reg.mem_hit && (out_item_reg.mem_select == SEL_SRAM))
        else $error("SRAM write flagged without an SRAM hit");

    a_none_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.mem_select == SEL_NONE)
            |-> (out_item_reg.mem_address == '0) && !out_item_reg.mem_hit)
        else $error("mapper write result carries an address or hit");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("stage 1 item lost or changed while blocked");

    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("item left stage 1 without reaching the result register");

endmodule

>>> bench/tb_cartridge_bank_mapper_unit.sv
// Testbench for cartridge_bank_mapper_unit: a bank-state scoreboard predicts every
// result from the accepted bus accesses, under random idling on both channels.
// Depends on cbm_pkg and the cartridge_bank_mapper_unit RTL only.
module tb_cartridge_bank_mapper_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    // Mapper type code above the supported range; writes must be ignored.
    localparam logic [2:0] MAPPER_UNUSED_TOP = 3'd7;

    localparam int unsigned PHASES          = 12;
    localparam int unsigned ITEMS_PER_PHASE = 118;
    localparam int unsigned PAUSE_PHASE     = 4;
    // Two-stage pipeline; extra idle wait after the drain to catch stray results.
    localparam int unsigned SETTLE_CYCLES   = 6;
    localparam int unsigned QUIET_LIMIT     = 2000;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the config and bank registers, computes the
    // memory access each bus item should produce and checks results in order.
    // ------------------------------------------------------------------
    class mapper_access_scoreboard;
        cfg_t        settings;
        bank_state_t banks;
        out_item_t   expected_accesses[$];
        int unsigned mismatches;

        function new();
            settings = '0;
            settings.mapper_type    = MAPPER_NONE;
            settings.rom_size_bytes = 24'h008000;
            settings.rom_size_log2  = 5'd15;
            banks = '0;
            banks.switch_rom_bank    = 9'd1;
            banks.ram_high_half_bank = 9'd1;
            mismatches = 0;
        endfunction

        function void apply_setting(logic [2:0] index, logic [23:0] value);
            case (index)
                CFG_MAPPER_TYPE:      settings.mapper_type      = value[2:0];
                CFG_MULTICART_WIRING: settings.multicart_wiring = value[0];
                CFG_ROM_SIZE_BYTES:   settings.rom_size_bytes   = value;
                CFG_ROM_SIZE_LOG2:    settings.rom_size_log2    = value[4:0];
                CFG_SRAM_SIZE_BYTES:  settings.sram_size_bytes  = value[17:0];
                CFG_SRAM_SIZE_LOG2:   settings.sram_size_log2   = value[4:0];
                default: ;
            endcase
        endfunction

        function void set_ram_pair(logic [7:0] pair);
            banks.ram_low_half_bank  = {pair, 1'b0};
            banks.ram_high_half_bank = {pair, 1'b1};
        endfunction

        // Upper bank bits placed where the wiring puts them in the ROM bank.
        function logic [7:0] upper_field();
            logic [7:0] up;
            up = {6'd0, banks.upper_bank_reg};
            return settings.multicart_wiring ? (up << 4) : (up << 5);
        endfunction

        function void write_type1(logic [14:0] a, logic [7:0] v);
            logic [7:0] t;
            logic [7:0] keep;
            logic       big;
            big  = settings.rom_size_bytes > BIG_ROM_LIMIT;
            keep = settings.multicart_wiring ? KEEP_MULTICART : KEEP_STANDARD;
            if (a < 15'h2000)
                banks.ram_enable = (v[3:0] == RAM_ENABLE_KEY);
            else if (a < 15'h4000)
            begin
                t = v & 8'h1f;
                if (t == 8'h00)
                    t = 8'h01;
                // multicart drops bit 4 after the zero fixup, so bank 0 can stick
                if (settings.multicart_wiring)
                    banks.low_bank_reg = (banks.low_bank_reg & 8'hf0) | (t & 8'h0f);
                else
                    banks.low_bank_reg = (banks.low_bank_reg & 8'he0) | t;
                banks.switch_rom_bank = {1'b0, banks.low_bank_reg};
            end
            else if (a < 15'h6000)
            begin
                banks.upper_bank_reg = v[1:0];
                if (big)
                begin
                    if (banks.mode_bit)
                        banks.fixed_rom_bank = {1'b0, upper_field()};
                    banks.low_bank_reg    = (banks.low_bank_reg & keep) | upper_field();
                    banks.switch_rom_bank = {1'b0, banks.low_bank_reg};
                end
                else if (banks.mode_bit)
                    set_ram_pair({6'd0, banks.upper_bank_reg});
            end
            else
            begin
                banks.mode_bit = v[0];
                if (banks.mode_bit)
                begin
                    if (big)
                        banks.fixed_rom_bank = {1'b0, upper_field()};
                    else
                        set_ram_pair({6'd0, banks.upper_bank_reg});
                end
                else
                begin
                    banks.fixed_rom_bank     = 9'd0;
                    banks.ram_low_half_bank  = 9'd0;
                    banks.ram_high_half_bank = 9'd1;
                end
            end
        endfunction

        function void write_type2(logic [14:0] a, logic [7:0] v);
            if (a < 15'h4000)
            begin
                if (a[8])
                begin
                    banks.switch_rom_bank = {5'd0, v[3:0]};
                    if (banks.switch_rom_bank == 9'd0)
                        banks.switch_rom_bank = 9'd1;
                end
                else
                    banks.ram_enable = (v[3:0] == RAM_ENABLE_KEY);
            end
        endfunction

        function void write_type3(logic [14:0] a, logic [7:0] v);
            if (a < 15'h2000)
                banks.ram_enable = (v[3:0] == RAM_ENABLE_KEY);
            else if (a < 15'h4000)
            begin
                banks.switch_rom_bank = {2'd0, v[6:0]};
                if (banks.switch_rom_bank == 9'd0)
                    banks.switch_rom_bank = 9'd1;
            end
            else if (a < 15'h6000)
                set_ram_pair({4'd0, v[3:0]});
            else
            begin
                // clock latch: a 0 then 1 sequence flips the mode bit
                if (banks.low_bank_reg == 8'h00 && v == 8'h01)
                    banks.mode_bit = ~banks.mode_bit;
                banks.low_bank_reg = v;
            end
        endfunction

        function void write_type5(logic [14:0] a, logic [7:0] v);
            if (a < 15'h2000)
                banks.ram_enable = (v[3:0] == RAM_ENABLE_KEY);
            else if (a < 15'h3000)
            begin
                banks.low_bank_reg    = v;
                banks.switch_rom_bank = {banks.mode_bit, banks.low_bank_reg};
            end
            else if (a < 15'h4000)
            begin
                banks.mode_bit        = v[0];
                banks.switch_rom_bank = {banks.mode_bit, banks.low_bank_reg};
            end
            else if (a < 15'h6000)
                set_ram_pair(v);
        endfunction

        function out_item_t map_access(in_item_t item);
            out_item_t   res;
            logic [31:0] bank;
            logic [31:0] offset;
            logic [31:0] addr;
            logic [31:0] limit;
            logic [4:0]  lg;
            logic [12:0] window;
            res = '0;
            case (item.op)
                OP_ROM_READ:
                begin
                    lg = (settings.rom_size_log2 > ROM_ADDR_BITS) ? ROM_ADDR_BITS
                                                                  : settings.rom_size_log2;
                    if (item.bus_address < 15'h4000)
                    begin
                        bank   = 32'(banks.fixed_rom_bank);
                        offset = 32'(item.bus_address);
                    end
                    else
                    begin
                        bank   = 32'(banks.switch_rom_bank);
                        offset = 32'(item.bus_address) - 32'h4000;
                    end
                    addr  = (bank * 32'h4000 + offset) & ((32'd1 << lg) - 32'd1);
                    limit = 32'(settings.rom_size_bytes);
                    res.mem_select  = SEL_ROM;
                    res.mem_address = addr[MEM_ADDR_W-1:0];
                    res.mem_hit     = addr < limit;
                end
                OP_MAPPER_WRITE:
                begin
                    case (settings.mapper_type)
                        MAPPER_TYPE1: write_type1(item.bus_address, item.write_data);
                        MAPPER_TYPE2: write_type2(item.bus_address, item.write_data);
                        MAPPER_TYPE3: write_type3(item.bus_address, item.write_data);
                        MAPPER_TYPE5: write_type5(item.bus_address, item.write_data);
                        default: ;
                    endcase
                end
                OP_SRAM_READ, OP_SRAM_WRITE:
                begin
                    lg = (settings.sram_size_log2 > SRAM_ADDR_BITS) ? SRAM_ADDR_BITS
                                                                    : settings.sram_size_log2;
                    window = item.bus_address[12:0];
                    if (window < 13'h1000)
                    begin
                        bank   = 32'(banks.ram_low_half_bank);
                        offset = 32'(window);
                    end
                    else
                    begin
                        bank   = 32'(banks.ram_high_half_bank);
                        offset = 32'(window) - 32'h1000;
                    end
                    addr  = (bank * 32'h1000 + offset) & ((32'd1 << lg) - 32'd1);
                    limit = 32'(settings.sram_size_bytes);
                    res.mem_select  = SEL_SRAM;
                    res.mem_address = addr[MEM_ADDR_W-1:0];
                    res.mem_hit     = banks.ram_enable && (addr < limit);
                    res.mem_write   = (item.op == OP_SRAM_WRITE) && res.mem_hit;
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_access(in_item_t item);
            expected_accesses.push_back(map_access(item));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_accesses.size() == 0)
            begin
                $display("%0t: result with no item pending: expected none, got %h",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_accesses.pop_front();
                if (got.mem_select !== want.mem_select)
                begin
                    $display("%0t: mem_select expected %0d got %0d",
                             $time, want.mem_select, got.mem_select);
                    mismatches++;
                end
                if (got.mem_address !== want.mem_address)
                begin
                    $display("%0t: mem_address expected %h got %h",
                             $time, want.mem_address, got.mem_address);
                    mismatches++;
                end
                if (got.mem_hit !== want.mem_hit)
                begin
                    $display("%0t: mem_hit expected %b got %b",
                             $time, want.mem_hit, got.mem_hit);
                    mismatches++;
                end
                if (got.mem_write !== want.mem_write)
                begin
                    $display("%0t: mem_write expected %b got %b",
                             $time, want.mem_write, got.mem_write);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_accesses.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    cartridge_bank_mapper_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mapper_access_scoreboard tracker = new();

    // Random idling switches; both go off for the final phase.
    bit   idle_enabled  = 1'b1;
    bit   stall_enabled = 1'b1;
    cfg_t phase_cfg [PHASES];
    cfg_t directed_cfg;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Both channels are sampled at the rising edge, before any register
    // in the DUT has moved; inputs only ever change on the falling edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_access(in_item);
            if (out_valid && !out_stall)
                tracker.check_result(out_item);
        end
    end

    // Result side back-pressure: random stall bursts.
    initial
    begin : result_backpressure
        int unsigned span;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_enabled && $urandom_range(0, 9) == 0)
            begin
                span = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (span) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Hang detection: too many cycles with no item moving on either side.
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers. All tasks start and end on a falling edge.
    // ------------------------------------------------------------------

    // Offer one item, hold it until accepted, then maybe leave a gap.
    task automatic send_access(input in_item_t item);
        int unsigned gap;
        in_valid <= 1'b1;
        in_item  <= item;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        @(negedge clk);
        if (idle_enabled && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_directed(input logic [1:0] op, input logic [14:0] address,
                                 input logic [7:0] data);
        in_item_t item;
        item.op          = op;
        item.bus_address = address;
        item.write_data  = data;
        send_access(item);
    endtask

    // Hold the sender off until every expected result is back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        tracker.apply_setting(index, value);
        @(negedge clk);
    endtask

    // Only called with the pipeline empty.
    task automatic load_setting(input cfg_t s);
        write_register(CFG_MAPPER_TYPE, 24'(s.mapper_type));
        write_register(CFG_MULTICART_WIRING, 24'(s.multicart_wiring));
        write_register(CFG_ROM_SIZE_BYTES, s.rom_size_bytes);
        write_register(CFG_ROM_SIZE_LOG2, 24'(s.rom_size_log2));
        write_register(CFG_SRAM_SIZE_BYTES, 24'(s.sram_size_bytes));
        write_register(CFG_SRAM_SIZE_LOG2, 24'(s.sram_size_log2));
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed bus traffic: RAM-enable keys land in the enable
    // region, latch-style 0/1 writes, zero bank selects, plus plain noise.
    function automatic in_item_t random_access();
        in_item_t    item;
        int unsigned pick;
        int unsigned flavor;
        pick   = $urandom_range(0, 99);
        flavor = $urandom_range(0, 9);
        item.bus_address = 15'($urandom_range(0, 15'h7fff));
        item.write_data  = 8'($urandom_range(0, 255));
        if (pick < 30)
        begin
            item.op = OP_MAPPER_WRITE;
            if (flavor < 3)
            begin
                item.bus_address[14:13] = 2'b00;
                item.write_data[3:0]    = RAM_ENABLE_KEY;
            end
            else if (flavor == 3)
            begin
                item.bus_address[14:13] = 2'b11;
                item.write_data         = 8'($urandom_range(0, 1));
            end
            else if (flavor == 4)
                item.write_data = 8'h00;
        end
        else if (pick < 60)
            item.op = OP_ROM_READ;
        else if (pick < 80)
            item.op = OP_SRAM_READ;
        else
            item.op = OP_SRAM_WRITE;
        return item;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_MAPPER_TYPE;
        cfg_data  = '0;

        // Settings walked by the random part: every mapper type, both wirings,
        // sizes from zero to the register maxima, oversized mask widths.
        phase_cfg[0]  = '{MAPPER_TYPE1, 1'b0, 24'h200000, 5'd21, 18'h08000, 5'd15};
        phase_cfg[1]  = '{MAPPER_TYPE1, 1'b1, 24'h100000, 5'd20, 18'h02000, 5'd13};
        phase_cfg[2]  = '{MAPPER_TYPE1, 1'b0, 24'h080000, 5'd19, 18'h08000, 5'd15};
        phase_cfg[3]  = '{MAPPER_TYPE2, 1'b0, 24'h040000, 5'd18, 18'h00200, 5'd9};
        phase_cfg[4]  = '{MAPPER_TYPE3, 1'b0, 24'h200000, 5'd21, 18'h08000, 5'd15};
        phase_cfg[5]  = '{MAPPER_TYPE5, 1'b0, 24'h800000, 5'd23, 18'h20000, 5'd17};
        phase_cfg[6]  = '{MAPPER_TYPE5, 1'b1, 24'h800000, 5'd31, 18'h20000, 5'd31};
        phase_cfg[7]  = '{MAPPER_NONE, 1'b0, 24'h008000, 5'd15, 18'h02000, 5'd13};
        phase_cfg[8]  = '{MAPPER_UNUSED_TOP, 1'b1, 24'h000000, 5'd0, 18'h00000, 5'd0};
        phase_cfg[9]  = '{MAPPER_TYPE1, 1'b1, 24'hffffff, 5'd23, 18'h3ffff, 5'd17};
        phase_cfg[10] = '{MAPPER_TYPE3, 1'b0, 24'h123456, 5'd21, 18'h03000, 5'd14};
        phase_cfg[11] = '{MAPPER_TYPE5, 1'b0, 24'h100000, 5'd20, 18'h10000, 5'd16};
        directed_cfg  = '{MAPPER_TYPE1, 1'b0, 24'h200000, 5'd31, 18'h08000, 5'd31};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Straight out of reset: no mapper, so the write is dropped and SRAM
        // stays disabled.
        send_directed(OP_ROM_READ, 15'h0000, 8'h00);
        send_directed(OP_MAPPER_WRITE, 15'h0000, 8'h0a);
        send_directed(OP_SRAM_READ, 15'h0000, 8'h00);

        // Type 1, large ROM, both mask widths above their ceilings.
        wait_for_results();
        load_setting(directed_cfg);
        send_directed(OP_MAPPER_WRITE, 15'h0000, 8'h0a);   // RAM on
        send_directed(OP_SRAM_WRITE, 15'h7fff, 8'hff);     // only 13 window bits count
        send_directed(OP_MAPPER_WRITE, 15'h2000, 8'h00);   // bank 0 reads as 1
        send_directed(OP_ROM_READ, 15'h7fff, 8'h00);
        send_directed(OP_MAPPER_WRITE, 15'h3fff, 8'hff);
        send_directed(OP_MAPPER_WRITE, 15'h4000, 8'h03);   // upper bits into ROM bank
        send_directed(OP_MAPPER_WRITE, 15'h6000, 8'h01);   // mode 1 moves fixed bank
        send_directed(OP_ROM_READ, 15'h3fff, 8'h00);
        send_directed(OP_ROM_READ, 15'h4000, 8'h00);
        send_directed(OP_SRAM_READ, 15'h1000, 8'h00);
        send_directed(OP_MAPPER_WRITE, 15'h1fff, 8'h00);   // RAM off
        send_directed(OP_SRAM_READ, 15'h0fff, 8'h00);      // miss, address still banked
        send_directed(OP_SRAM_WRITE, 15'h1fff, 8'h5a);
        send_directed(OP_MAPPER_WRITE, 15'h6000, 8'h00);
        send_directed(OP_MAPPER_WRITE, 15'h7fff, 8'hfe);
        send_directed(OP_ROM_READ, 15'h0000, 8'hff);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_for_results();
            // Last phase runs flat out on both sides.
            if (ph == PHASES - 1)
            begin
                idle_enabled  = 1'b0;
                stall_enabled = 1'b0;
            end
            load_setting(phase_cfg[ph]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // one mid-phase full drain with the config untouched
                if (ph == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
                    wait_for_results();
                send_access(random_access());
            end
        end

        wait_for_results();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/cbm_pkg.sv
src/cbm_bank_regs.sv
src/cbm_addr_map.sv
src/cartridge_bank_mapper_unit.sv
bench/tb_cartridge_bank_mapper_unit.sv
